### rtl/tgl_pkg.sv
// Shared types, constants and the square-pattern table for the text glyph layout block.
// Used by every module of the block; has no dependencies of its own.
package tgl_pkg;

    localparam int CoordBits     = 16;
    localparam int ScaleBits     = 5;
    localparam int SrcBits       = 10;
    localparam int QueueDepth    = 4;
    localparam int QueueAddrBits = $clog2(QueueDepth);
    localparam int StepBits      = 5;
    localparam int BigNDraws     = 19;
    localparam int SmallNDraws   = 11;

    localparam logic [ScaleBits-1:0] ScaleReset = 5'd1;

    localparam logic [7:0] CharTab        = 8'h09;
    localparam logic [7:0] CharNewline    = 8'h0A;
    localparam logic [7:0] CharSpace      = 8'h20;
    localparam logic [7:0] CharBigN       = 8'h4E;
    localparam logic [7:0] CharSmallN     = 8'h6E;
    localparam logic [7:0] FirstPrintable = 8'd33;

    localparam logic [SrcBits-1:0] PlaceholderSrc = 10'd376;
    localparam logic [3:0]         LineAdvance    = 4'd11;

    localparam logic DRAW_GLYPH  = 1'b0;
    localparam logic DRAW_SQUARE = 1'b1;

    typedef logic [CoordBits-1:0] tgl_coord_t;

    typedef struct packed {
        logic [7:0]                  char_code;
        logic                        first_of_string;
        logic signed [CoordBits-1:0] start_x;
        logic signed [CoordBits-1:0] start_y;
    } tgl_in_t;

    typedef struct packed {
        logic                        draw_kind;
        logic [SrcBits-1:0]          source_x;
        logic signed [CoordBits-1:0] dest_x;
        logic signed [CoordBits-1:0] dest_y;
        logic                        last;
    } tgl_out_t;

    typedef enum logic [1:0] {
        CMD_GLYPH,
        CMD_BIG_N,
        CMD_SMALL_N
    } tgl_cmd_kind_t;

    // One queued drawing job: a single glyph copy or a whole square pattern.
    typedef struct packed {
        tgl_cmd_kind_t      kind;
        logic [SrcBits-1:0] source_x;
        tgl_coord_t         pen_x;
        tgl_coord_t         pen_y;
    } tgl_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } tgl_q_status_t;

    typedef struct packed {
        logic [2:0] col;
        logic [3:0] row;
    } tgl_pos_t;

    // Square positions of the N and n patterns, column by column, top to bottom.
    function automatic tgl_pos_t n_pos(input logic big, input logic [StepBits-1:0] step);
        tgl_pos_t p;
        if (big) begin
            if (step < 5'd9) begin
                p.col = 3'd0;
                p.row = 4'(step);
            end else if (step == 5'd9) begin
                p.col = 3'd2;
                p.row = 4'd5;
            end else begin
                p.col = 3'd4;
                p.row = 4'(step - 5'd9);
            end
        end else begin
            if (step < 5'd5) begin
                p.col = 3'd0;
                p.row = 4'(step + 5'd4);
            end else if (step == 5'd5) begin
                p.col = 3'd2;
                p.row = 4'd6;
            end else begin
                p.col = 3'd4;
                p.row = 4'(step - 5'd1);
            end
        end
        return p;
    endfunction

endpackage

### rtl/tgl_front.sv
// Front end: accepts characters, keeps the pen state and queues drawing jobs.
// Depends on tgl_pkg.
module tgl_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tgl_pkg::ScaleBits-1:0]  scale,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tgl_pkg::tgl_in_t               s_data,
    input  tgl_pkg::tgl_q_status_t         q_status,
    output logic                           q_push,
    output tgl_pkg::tgl_cmd_t              q_cmd
);
    import tgl_pkg::*;

    tgl_coord_t pen_x_reg, pen_x_next;
    tgl_coord_t pen_y_reg, pen_y_next;
    tgl_coord_t line_x_reg, line_x_next;

    tgl_coord_t base_x, base_y, base_line;
    tgl_coord_t adv4, adv16, adv6, adv_line;
    logic       accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        adv4     = CoordBits'({scale, 2'b00});
        adv16    = CoordBits'({scale, 4'b0000});
        adv6     = CoordBits'(8'(scale) * 8'd6);
        adv_line = CoordBits'(9'(scale) * 9'(LineAdvance));

        if (s_data.first_of_string) begin
            base_x    = s_data.start_x;
            base_y    = s_data.start_y;
            base_line = s_data.start_x;
        end else begin
            base_x    = pen_x_reg;
            base_y    = pen_y_reg;
            base_line = line_x_reg;
        end

        q_push       = 1'b0;
        q_cmd.kind   = CMD_GLYPH;
        q_cmd.source_x = '0;
        q_cmd.pen_x  = base_x;
        q_cmd.pen_y  = base_y;
        pen_x_next   = base_x + adv4;
        pen_y_next   = base_y;
        line_x_next  = base_line;

        case (s_data.char_code)
            CharNewline: begin
                pen_x_next = base_line;
                pen_y_next = base_y + adv_line;
            end
            CharSpace: begin
                pen_x_next = base_x + adv4;
            end
            CharTab: begin
                pen_x_next = base_x + adv16;
            end
            CharBigN: begin
                q_push     = accept;
                q_cmd.kind = CMD_BIG_N;
                pen_x_next = base_x + adv6;
            end
            CharSmallN: begin
                q_push     = accept;
                q_cmd.kind = CMD_SMALL_N;
                pen_x_next = base_x + adv6;
            end
            default: begin
                q_push = accept;
                if (s_data.char_code < FirstPrintable) begin
                    q_cmd.source_x = PlaceholderSrc;
                end else begin
                    q_cmd.source_x = {8'(s_data.char_code - FirstPrintable), 2'b00};
                end
            end
        endcase

        if (!accept) begin
            pen_x_next  = pen_x_reg;
            pen_y_next  = pen_y_reg;
            line_x_next = line_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
        end else begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
        end
    end

endmodule

### rtl/tgl_queue.sv
// Short job queue between the front end and the draw sequencer.
// Depends on tgl_pkg.
module tgl_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  tgl_pkg::tgl_cmd_t      push_cmd,
    input  logic                   pop,
    output tgl_pkg::tgl_cmd_t      head_cmd,
    output tgl_pkg::tgl_q_status_t status
);
    import tgl_pkg::*;

    tgl_cmd_t                 entry_reg [QueueDepth];
    logic [QueueAddrBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueueAddrBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueAddrBits:0]   count_reg, count_next;

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QueueAddrBits+1)'(QueueDepth));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/tgl_back.sv
// Draw sequencer: turns queued jobs into draw transfers, one per cycle unless m_ready stalls.
// Depends on tgl_pkg.
module tgl_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tgl_pkg::ScaleBits-1:0]  scale,
    input  tgl_pkg::tgl_cmd_t              head_cmd,
    input  tgl_pkg::tgl_q_status_t         q_status,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tgl_pkg::tgl_out_t              m_data
);
    import tgl_pkg::*;

    logic                m_valid_reg, m_valid_next;
    tgl_out_t            m_data_reg, m_data_next;
    logic [StepBits-1:0] step_reg, step_next;

    tgl_pos_t  pos;
    tgl_out_t  draw;
    logic      load;
    logic      is_square;
    logic      last_draw;
    logic [7:0] x_off;
    logic [8:0] y_off;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        load      = !q_status.empty && (!m_valid_reg || m_ready);
        is_square = (head_cmd.kind == CMD_BIG_N) || (head_cmd.kind == CMD_SMALL_N);
        pos       = n_pos(head_cmd.kind == CMD_BIG_N, step_reg);
        x_off     = 8'(pos.col) * 8'(scale);
        y_off     = 9'(pos.row) * 9'(scale);

        if (!is_square) begin
            last_draw = 1'b1;
        end else if (head_cmd.kind == CMD_BIG_N) begin
            last_draw = (step_reg == StepBits'(BigNDraws - 1));
        end else begin
            last_draw = (step_reg == StepBits'(SmallNDraws - 1));
        end

        draw.last = last_draw;
        if (is_square) begin
            draw.draw_kind = DRAW_SQUARE;
            draw.source_x  = '0;
            draw.dest_x    = head_cmd.pen_x + CoordBits'(x_off);
            draw.dest_y    = head_cmd.pen_y + CoordBits'(y_off);
        end else begin
            draw.draw_kind = DRAW_GLYPH;
            draw.source_x  = head_cmd.source_x;
            draw.dest_x    = head_cmd.pen_x;
            draw.dest_y    = head_cmd.pen_y;
        end

        q_pop = load && last_draw;

        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = draw;
            step_next    = last_draw ? '0 : step_reg + 1'b1;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
            step_next    = step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
        end
    end

endmodule

### rtl/text_glyph_layout.sv
// Top level of the text glyph layout block: scale register, front end, job queue, sequencer.
// Depends on tgl_pkg, tgl_front, tgl_queue and tgl_back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    tgl_in_t: one character
//   m_        out        m_valid / m_ready    tgl_out_t: one draw
//   cfg_      in         cfg_valid/cfg_ready  5-bit scale
//
// A character is accepted whenever the four-entry job queue has room; newline, space
// and tab only move the pen and queue no jobs for the sequencer. Unless m_ready stalls
// it, the sequencer emits one draw per cycle: one for a glyph, 19 for N and 11 for n,
// so the draw output port sets the sustained rate. The first draw passes the queue
// entry, then the output register. Reset (aresetn, synchronous) clears the pen, the queue
// and sets scale to 1. A stalled m_ready holds the output register and backs up the queue.
module text_glyph_layout (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tgl_pkg::tgl_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tgl_pkg::tgl_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tgl_pkg::ScaleBits-1:0] cfg_data
);
    import tgl_pkg::*;

    logic [ScaleBits-1:0] scale_reg, scale_next;
    tgl_q_status_t        q_status;
    tgl_cmd_t             push_cmd, head_cmd;
    logic                 q_push, q_pop;

    assign cfg_ready  = 1'b1;
    assign scale_next = (cfg_valid && cfg_ready) ? cfg_data : scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= ScaleReset;
        end else begin
            scale_reg <= scale_next;
        end
    end

    tgl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scale    (scale_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    tgl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    tgl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scale    (scale_reg),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
